/* hdl/wbss_pkg.sv */
// Shared types and constants for the wildcard byte signature scan unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package wbss_pkg;

  // Fixed sizes of the pattern registers and result fields.
  localparam int PATTERN_SLOTS    = 16;
  localparam int MIN_BUFFER_BYTES = 16;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_INDEX_W      = 3;
  localparam int POS_W            = 25;
  localparam int TARGET_W         = 33;
  localparam int STATUS_W         = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISP_OFFSET  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_INSN_LENGTH  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_MODE  = 3'd6;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DISP_ERR  = 2'd2;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [POS_W-1:0]           position;
    logic signed [TARGET_W-1:0] target;
  } result_t;

endpackage

/* hdl/wildcard_byte_signature_scan_unit.sv */
// Top level of the wildcard byte signature scan unit: window, compare,
// displacement resolve and a two-entry output stage. Depends on wbss_pkg.
// A result is registered in the output register, or in its skid entry, before the master side sees it.
// Throughput: one byte per cycle, with the window compare and resolve add done combinationally.
// The input stalls only when both the output register and its skid entry are full.
// Reset (synchronous, active high) clears the config registers, byte count, flags and output valid.
`timescale 1ns / 1ps

module wildcard_byte_signature_scan_unit
  import wbss_pkg::*;
#(
  parameter int WINDOW_BYTES   = 16,
  parameter int MAX_SCAN_BYTES = 33554432
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Byte stream in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tlast,   // last_byte
  // Result stream out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [63:0]            m_axis_tdata,   // [24:0] match_position, [57:25] target_value
  output logic [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

  localparam int IDX_W = $clog2(WINDOW_BYTES);
  localparam int CNT_W = $clog2(MAX_SCAN_BYTES + 1);
  localparam int PW    = $clog2(WINDOW_BYTES + PATTERN_SLOTS + 1) + 1;

  // Configuration registers
  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [15:0] compare_mask;
  logic [4:0]  pattern_length;
  logic [3:0]  disp_offset;
  logic [7:0]  insn_length;
  logic        target_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      compare_mask   <= '0;
      pattern_length <= '0;
      disp_offset    <= '0;
      insn_length    <= '0;
      target_mode    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PATTERN_LOW:  pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH: pattern_high   <= cfg_data;
        CFG_MASK:         compare_mask   <= cfg_data[15:0];
        CFG_LENGTH:       pattern_length <= cfg_data[4:0];
        CFG_DISP_OFFSET:  disp_offset    <= cfg_data[3:0];
        CFG_INSN_LENGTH:  insn_length    <= cfg_data[7:0];
        CFG_TARGET_MODE:  target_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Buffer state
  logic [7:0]       window [WINDOW_BYTES];
  logic [CNT_W-1:0] byte_count;
  logic             match_reported;
  logic             pend_valid;
  result_t          pend;

  logic in_accept;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Window after shifting in the new byte; oldest at index 0.
  logic [7:0]       window_next [WINDOW_BYTES];
  logic             below_limit;
  logic [CNT_W-1:0] byte_count_next;

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      window_next[i] = window[i + 1];
    end
    window_next[WINDOW_BYTES - 1] = s_axis_tdata;
  end

  assign below_limit     = byte_count < CNT_W'(MAX_SCAN_BYTES);
  assign byte_count_next = byte_count + CNT_W'(1);

  // Pattern compare over the newest pattern_length bytes.
  logic [PW-1:0] base;
  logic [15:0]   byte_ok;
  logic          length_ok;
  logic          pattern_hit;
  logic [127:0]  pattern_all;
  logic [PW-1:0] idx;

  assign pattern_all = {pattern_high, pattern_low};
  assign base        = PW'(WINDOW_BYTES) - PW'(pattern_length);
  assign length_ok   = (pattern_length != 5'd0)
                    && (PW'(pattern_length) <= PW'(PATTERN_SLOTS))
                    && (PW'(pattern_length) <= PW'(WINDOW_BYTES))
                    && (byte_count_next >= CNT_W'(pattern_length));

  always_comb begin
    for (int j = 0; j < PATTERN_SLOTS; j++) begin
      idx = base + PW'(j);
      // Unused slots and wildcard slots always pass.
      byte_ok[j] = (PW'(j) >= PW'(pattern_length)) || !compare_mask[j]
                || (window_next[idx[IDX_W-1:0]] == pattern_all[8*j +: 8]);
    end
  end

  assign pattern_hit = length_ok && (&byte_ok);

  // Displacement gather and target resolve.
  logic [31:0]         disp;
  logic [PW-1:0]       didx;
  logic                disp_outside;
  logic [CNT_W-1:0]    match_pos;
  logic [TARGET_W-1:0] pos_ext;
  result_t             fresh;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      didx = base + PW'(disp_offset) + PW'(k);
      disp[8*k +: 8] = window_next[didx[IDX_W-1:0]];
    end
  end

  assign disp_outside = (6'(disp_offset) + 6'd4) > 6'(pattern_length);
  assign match_pos    = byte_count_next - CNT_W'(pattern_length);
  assign pos_ext      = TARGET_W'(match_pos);

  always_comb begin
    fresh.position = pos_ext[POS_W-1:0];
    if (disp_outside) begin
      fresh.status = ST_DISP_ERR;
      fresh.target = '0;
    end else begin
      fresh.status = ST_FOUND;
      if (target_mode) begin
        fresh.target = {1'b0, disp};
      end else begin
        fresh.target = pos_ext + TARGET_W'(insn_length) + {disp[31], disp};
      end
    end
  end

  // Report decision for the accepted byte.
  logic    emit_match;
  logic    push;
  result_t push_item;

  assign emit_match = below_limit && !match_reported && (pend_valid || pattern_hit)
                   && (byte_count_next >= CNT_W'(MIN_BUFFER_BYTES));
  assign push       = in_accept && (emit_match || (s_axis_tlast && !match_reported));

  always_comb begin
    if (emit_match) begin
      push_item = pend_valid ? pend : fresh;
    end else begin
      push_item.status   = ST_NOT_FOUND;
      push_item.position = '0;
      push_item.target   = '0;
    end
  end

  // Window shift (contents need no reset: only bytes of the current buffer are read).
  always_ff @(posedge clk) begin
    if (in_accept && below_limit) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

  // Buffer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      match_reported <= 1'b0;
      pend_valid     <= 1'b0;
    end else if (in_accept) begin
      if (s_axis_tlast) begin
        byte_count     <= '0;
        match_reported <= 1'b0;
        pend_valid     <= 1'b0;
      end else if (below_limit) begin
        byte_count <= byte_count_next;
        if (emit_match) begin
          match_reported <= 1'b1;
        end
        if (!match_reported && !pend_valid && pattern_hit) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // Pending match held until the buffer reaches its minimum length.
  always_ff @(posedge clk) begin
    if (in_accept && below_limit && !match_reported && !pend_valid && pattern_hit) begin
      pend <= fresh;
    end
  end

  // Output register with one skid entry behind it.
  result_t out_item;
  result_t skid_item;
  logic    skid_valid;
  logic    pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid) begin
      if (push) begin
        m_axis_tvalid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        m_axis_tvalid <= 1'b0;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || pop) begin
      if (m_axis_tvalid && skid_valid) begin
        out_item <= skid_item;
      end else if (push) begin
        out_item <= push_item;
      end
    end else if (push) begin
      skid_item <= push_item;
    end
  end

  assign m_axis_tdata = {6'd0, out_item.target, out_item.position};
  assign m_axis_tuser = out_item.status;

  // Checks on the internal control.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry holds an item while the output register is empty");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tlast) |=> (byte_count == '0) && !match_reported && !pend_valid)
    else $error("buffer state not cleared after the last byte");

  a_not_found_on_last: assert property (@(posedge clk) disable iff (rst)
    (push && (push_item.status == ST_NOT_FOUND)) |-> s_axis_tlast)
    else $error("not-found result raised before the end of the buffer");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(MAX_SCAN_BYTES))
    else $error("byte count beyond the scan limit");

  a_single_report: assert property (@(posedge clk) disable iff (rst)
    (in_accept && match_reported && !s_axis_tlast) |-> !push)
    else $error("second result raised for one buffer");

endmodule
